// ----- rtl/sam_pkg.sv -----
`default_nettype none

package sam_pkg;

  // Width of the per-frame sample index; the index saturates at its all-ones value.
  localparam int INDEX_WIDTH = 16;

  localparam int DATA_WIDTH  = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int CFG_ADDR_WIDTH = 2;

  // Widths that cover both the index and the 16-bit quantities it is compared with.
  localparam int CMP_WIDTH   = (INDEX_WIDTH > COUNT_WIDTH) ? INDEX_WIDTH : COUNT_WIDTH;
  localparam int CLAMP_WIDTH = (INDEX_WIDTH > COUNT_WIDTH + 1) ? INDEX_WIDTH : COUNT_WIDTH + 1;
  localparam int PROD_WIDTH  = (INDEX_WIDTH > COUNT_WIDTH + 7) ? INDEX_WIDTH : COUNT_WIDTH + 7;

  localparam int CLIP_PERCENT_SCALE = 100;

  localparam logic [DATA_WIDTH-1:0] CLIP_THRESHOLD_RESET    = 16'd32440;
  localparam logic [DATA_WIDTH-1:0] SILENCE_THRESHOLD_RESET = 16'd33;
  localparam logic [DATA_WIDTH-1:0] MIN_DROPOUT_RESET       = 16'd100;

  typedef enum logic [CFG_ADDR_WIDTH-1:0] {
    CFG_CLIP_THRESHOLD    = 2'd0,
    CFG_SILENCE_THRESHOLD = 2'd1,
    CFG_MIN_DROPOUT       = 2'd2
  } cfg_reg_t;

  localparam logic KIND_DROPOUT = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic                   kind;
    logic                   is_last;
    logic [COUNT_WIDTH-1:0] run_start;
    logic [COUNT_WIDTH-1:0] run_end;
    logic [COUNT_WIDTH-1:0] clip_count;
    logic                   clip_flag;
    logic [COUNT_WIDTH-1:0] dropout_count;
    logic                   dropout_flag;
    logic [COUNT_WIDTH-1:0] crossing_count;
    logic [COUNT_WIDTH-1:0] sample_count;
  } result_t;

  // Which of the two result slots an accepted sample fills.
  typedef struct packed {
    logic first_valid;
    logic second_valid;
  } push_t;

  function automatic logic [COUNT_WIDTH-1:0] clamp_index(input logic [INDEX_WIDTH-1:0] v);
    logic [CLAMP_WIDTH-1:0] wide;
    wide = CLAMP_WIDTH'(v);
    if (wide > CLAMP_WIDTH'({COUNT_WIDTH{1'b1}})) begin
      return {COUNT_WIDTH{1'b1}};
    end
    return wide[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
    return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/sam_sample_if.sv -----
`default_nettype none

interface sam_sample_if import sam_pkg::*; ();
  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] sample;
  logic                         frame_end;

  modport source (output valid, output sample, output frame_end, input ready);
  modport sink (input valid, input sample, input frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/sam_result_if.sv -----
`default_nettype none

interface sam_result_if import sam_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   kind;
  logic                   is_last;
  logic [COUNT_WIDTH-1:0] run_start;
  logic [COUNT_WIDTH-1:0] run_end;
  logic [COUNT_WIDTH-1:0] clip_count;
  logic                   clip_flag;
  logic [COUNT_WIDTH-1:0] dropout_count;
  logic                   dropout_flag;
  logic [COUNT_WIDTH-1:0] crossing_count;
  logic [COUNT_WIDTH-1:0] sample_count;

  modport source (
    output valid, output kind, output is_last, output run_start, output run_end,
    output clip_count, output clip_flag, output dropout_count, output dropout_flag,
    output crossing_count, output sample_count, input ready
  );
  modport sink (
    input valid, input kind, input is_last, input run_start, input run_end,
    input clip_count, input clip_flag, input dropout_count, input dropout_flag,
    input crossing_count, input sample_count, output ready
  );
endinterface

`default_nettype wire

// ----- rtl/sample_artifact_monitor_core.sv -----
`default_nettype none

// Audio clipping and dropout monitor. Samples arrive one per transfer on
// samples, with frame_end on the last sample of a frame; each accepted
// sample updates the clip, zero-crossing and silent-run trackers at once.
// A silent run closed by a loud sample more than min_dropout_length
// samples after its start yields a dropout record; the last sample of a
// frame yields a frame summary (after any dropout record it closes) and
// clears all frame state. Results leave through a three-entry queue:
// samples keep flowing at one per cycle while at most one result is
// waiting, and a sample that produces two results queues both, the
// dropout record ahead of the summary. Configuration writes take effect
// at the next cycle and are meant to be made while no results are pending.
module sample_artifact_monitor_core import sam_pkg::*; (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_wr_en,
  input  wire logic [CFG_ADDR_WIDTH-1:0] cfg_addr,
  input  wire logic [DATA_WIDTH-1:0]     cfg_wdata,
  sam_sample_if.sink                     samples,
  sam_result_if.source                   results
);

  logic [DATA_WIDTH-1:0]  clip_threshold;
  logic [DATA_WIDTH-1:0]  silence_threshold;
  logic [DATA_WIDTH-1:0]  min_dropout_length;

  logic [INDEX_WIDTH-1:0] sample_index;
  logic                   previous_negative;
  logic                   in_silent_run;
  logic [INDEX_WIDTH-1:0] silent_run_start;
  logic [COUNT_WIDTH-1:0] clipped_total;
  logic [COUNT_WIDTH-1:0] dropout_total;
  logic [COUNT_WIDTH-1:0] crossing_total;

  logic                   accept;
  logic                   negative;
  logic [DATA_WIDTH:0]    mag;
  logic                   silent;
  logic                   clipped;
  logic                   crossing;
  logic [INDEX_WIDTH-1:0] run_length;
  logic                   dropout;
  logic [INDEX_WIDTH-1:0] index_inc;
  logic [COUNT_WIDTH-1:0] clipped_new;
  logic [COUNT_WIDTH-1:0] dropout_new;
  logic [COUNT_WIDTH-1:0] crossing_new;
  logic [PROD_WIDTH-1:0]  clip_scaled;
  logic                   clip_flag;

  result_t                drop_rec;
  result_t                summ_rec;
  result_t                first_rec;
  push_t                  push;
  logic                   queue_room;
  logic                   head_valid;
  result_t                head;

  // Configuration registers; an unknown index is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      clip_threshold     <= CLIP_THRESHOLD_RESET;
      silence_threshold  <= SILENCE_THRESHOLD_RESET;
      min_dropout_length <= MIN_DROPOUT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        CFG_CLIP_THRESHOLD:    clip_threshold     <= cfg_wdata;
        CFG_SILENCE_THRESHOLD: silence_threshold  <= cfg_wdata;
        CFG_MIN_DROPOUT:       min_dropout_length <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign accept        = samples.valid && samples.ready;
  assign samples.ready = queue_room;

  // The magnitude is one bit wider so that the most negative sample maps to 32768.
  always_comb begin
    negative = samples.sample[DATA_WIDTH-1];
    if (negative) begin
      mag = (DATA_WIDTH+1)'(1 << DATA_WIDTH) - {1'b0, samples.sample};
    end else begin
      mag = {1'b0, samples.sample};
    end
    silent   = mag < {1'b0, silence_threshold};
    clipped  = mag >= {1'b0, clip_threshold};
    crossing = (sample_index != '0) && (negative != previous_negative);

    // The index never decreases within a frame, so the run length cannot wrap.
    run_length = sample_index - silent_run_start;
    dropout    = !silent && in_silent_run &&
                 (CMP_WIDTH'(run_length) > CMP_WIDTH'(min_dropout_length));

    index_inc    = (sample_index == '1) ? sample_index : sample_index + 1'b1;
    clipped_new  = clipped ? sat_inc(clipped_total) : clipped_total;
    dropout_new  = dropout ? sat_inc(dropout_total) : dropout_total;
    crossing_new = crossing ? sat_inc(crossing_total) : crossing_total;
    clip_scaled  = PROD_WIDTH'(clipped_new) * PROD_WIDTH'(CLIP_PERCENT_SCALE);
    clip_flag    = clip_scaled > PROD_WIDTH'(index_inc);
  end

  always_comb begin
    drop_rec           = '0;
    drop_rec.kind      = KIND_DROPOUT;
    drop_rec.is_last   = !samples.frame_end;
    drop_rec.run_start = clamp_index(silent_run_start);
    drop_rec.run_end   = clamp_index(sample_index);

    summ_rec                = '0;
    summ_rec.kind           = KIND_SUMMARY;
    summ_rec.is_last        = 1'b1;
    summ_rec.clip_count     = clipped_new;
    summ_rec.clip_flag      = clip_flag;
    summ_rec.dropout_count  = dropout_new;
    summ_rec.dropout_flag   = (dropout_new != '0);
    summ_rec.crossing_count = crossing_new;
    summ_rec.sample_count   = clamp_index(index_inc);

    first_rec         = dropout ? drop_rec : summ_rec;
    push.first_valid  = accept && (dropout || samples.frame_end);
    push.second_valid = accept && dropout && samples.frame_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index      <= '0;
      previous_negative <= 1'b0;
      in_silent_run     <= 1'b0;
      silent_run_start  <= '0;
      clipped_total     <= '0;
      dropout_total     <= '0;
      crossing_total    <= '0;
    end else if (accept) begin
      if (samples.frame_end) begin
        sample_index      <= '0;
        previous_negative <= 1'b0;
        in_silent_run     <= 1'b0;
        silent_run_start  <= '0;
        clipped_total     <= '0;
        dropout_total     <= '0;
        crossing_total    <= '0;
      end else begin
        sample_index      <= index_inc;
        previous_negative <= negative;
        clipped_total     <= clipped_new;
        dropout_total     <= dropout_new;
        crossing_total    <= crossing_new;
        if (silent && !in_silent_run) begin
          in_silent_run    <= 1'b1;
          silent_run_start <= sample_index;
        end else if (!silent && in_silent_run) begin
          in_silent_run <= 1'b0;
        end
      end
    end
  end

  sam_result_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .first      (first_rec),
    .second     (summ_rec),
    .pop        (results.ready),
    .room       (queue_room),
    .head_valid (head_valid),
    .head       (head)
  );

  assign results.valid          = head_valid;
  assign results.kind           = head.kind;
  assign results.is_last        = head.is_last;
  assign results.run_start      = head.run_start;
  assign results.run_end        = head.run_end;
  assign results.clip_count     = head.clip_count;
  assign results.clip_flag      = head.clip_flag;
  assign results.dropout_count  = head.dropout_count;
  assign results.dropout_flag   = head.dropout_flag;
  assign results.crossing_count = head.crossing_count;
  assign results.sample_count   = head.sample_count;

endmodule

`default_nettype wire

// ----- rtl/sam_result_queue.sv -----
`default_nettype none

// Three-entry result queue. Head sits in slot zero; up to two entries are
// pushed per cycle, so room is only offered while at most one entry waits.
module sam_result_queue import sam_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire push_t   push,
  input  wire result_t first,
  input  wire result_t second,
  input  wire logic    pop,
  output logic         room,
  output logic         head_valid,
  output result_t      head
);

  localparam int DEPTH = 3;

  result_t    slot [DEPTH];
  result_t    slot_next [DEPTH];
  logic [1:0] count;
  logic [1:0] count_next;
  logic [1:0] count_after;
  logic       do_pop;

  assign do_pop     = pop && (count != 2'd0);
  assign room       = (count <= 2'd1);
  assign head_valid = (count != 2'd0);
  assign head       = slot[0];

  always_comb begin
    count_after = count - {1'b0, do_pop};
    for (int i = 0; i < DEPTH; i++) begin
      if (do_pop && i < DEPTH - 1) begin
        slot_next[i] = slot[(i < DEPTH - 1) ? i + 1 : i];
      end else begin
        slot_next[i] = slot[i];
      end
      if (push.first_valid && count_after == 2'(i)) begin
        slot_next[i] = first;
      end
      if (push.second_valid && count_after + 2'd1 == 2'(i)) begin
        slot_next[i] = second;
      end
    end
    count_next = count_after + {1'b0, push.first_valid} + {1'b0, push.second_valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      slot[i] <= slot_next[i];
    end
  end

endmodule

`default_nettype wire
